>>> hdl/cell_reference_parser_assert.svh
// assertion macros shared by the cell reference parser modules
// no dependencies; included by the modules that check their own logic
`ifndef CELL_REFERENCE_PARSER_ASSERT_SVH
`define CELL_REFERENCE_PARSER_ASSERT_SVH

// same-cycle implication
`define CRP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cell reference parser check failed");

// next-cycle implication
`define CRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cell reference parser check failed");

`endif

>>> hdl/crp_pkg.sv
// shared constants and types of the cell reference parser
// no dependencies
package crp_pkg;

  localparam int MAX_LETTERS = 2;
  localparam int MAX_DIGITS  = 5;

  localparam int LETTER_CNT_W = $clog2(MAX_LETTERS + 2);
  localparam int DIGIT_CNT_W  = $clog2(MAX_DIGITS + 2);

  localparam int CHAR_W      = 8;
  localparam int ROW_W       = 15;
  localparam int COL_W       = 10;
  localparam int COL_ACC_W   = 11;
  localparam int ROW_ACC_W   = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [COL_ACC_W-1:0] COL_SAT = 11'd1024;
  localparam logic [ROW_ACC_W-1:0] ROW_SAT = 17'd131071;

  localparam int RADIX_COL = 26;
  localparam int RADIX_ROW = 10;

  localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z      = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9      = 8'h39;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_LIMIT = 2'd1;

  localparam logic [ROW_W-1:0] ROW_LIMIT_RESET    = 15'd32767;
  localparam logic [COL_W-1:0] COLUMN_LIMIT_RESET = 10'd702;

  typedef struct packed {
    logic                    col_abs;
    logic                    row_abs;
    logic [LETTER_CNT_W-1:0] letter_count;
    logic [COL_ACC_W-1:0]    column_accum;
    logic [DIGIT_CNT_W-1:0]  digit_count;
    logic [ROW_ACC_W-1:0]    row_accum;
    logic                    row_bad;
  } parse_t;

endpackage

>>> hdl/crp_cfg.sv
// limit registers of the cell reference parser
// depends on crp_pkg
module crp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [crp_pkg::ROW_W-1:0]       row_limit,
  output logic [crp_pkg::COL_W-1:0]       column_limit
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_limit    <= crp_pkg::ROW_LIMIT_RESET;
      column_limit <= crp_pkg::COLUMN_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        crp_pkg::REG_ROW_LIMIT: begin
          row_limit <= cfg_data[crp_pkg::ROW_W-1:0];
        end
        crp_pkg::REG_COLUMN_LIMIT: begin
          column_limit <= cfg_data[crp_pkg::COL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hdl/crp_step.sv
// input register and per-character parse state of the cell reference parser
// depends on crp_pkg and cell_reference_parser_assert.svh
`include "cell_reference_parser_assert.svh"

module crp_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [crp_pkg::CHAR_W-1:0] char_code,
  input  logic                       is_last,
  input  logic                       out_free,
  output logic                       fin_valid,
  output crp_pkg::parse_t            fin
);

  typedef enum logic [1:0] {
    PHASE_START,
    PHASE_LETTERS,
    PHASE_ROW
  } phase_t;

  logic                       s0_valid;
  logic [crp_pkg::CHAR_W-1:0] s0_char;
  logic                       s0_last;
  logic                       s0_adv;

  phase_t          phase;
  phase_t          phase_next;
  crp_pkg::parse_t cur;
  crp_pkg::parse_t cur_next;

  logic                                 consumed;
  logic                                 take_row;
  logic                                 is_letter;
  logic                                 is_digit;
  logic [crp_pkg::CHAR_W-1:0]           letter_val;
  logic [crp_pkg::CHAR_W-1:0]           digit_val;
  logic [crp_pkg::COL_ACC_W+4:0]        col_sum;
  logic [crp_pkg::ROW_ACC_W+3:0]        row_sum;

  assign s0_adv    = s0_valid && (!s0_last || out_free);
  assign in_ready  = !s0_valid || s0_adv;
  assign fin_valid = s0_adv && s0_last;
  assign fin       = cur_next;

  assign is_letter  = (s0_char >= crp_pkg::CHAR_A) && (s0_char <= crp_pkg::CHAR_Z);
  assign is_digit   = (s0_char >= crp_pkg::CHAR_0) && (s0_char <= crp_pkg::CHAR_9);
  assign letter_val = s0_char - crp_pkg::CHAR_A + 8'd1;
  assign digit_val  = s0_char - crp_pkg::CHAR_0;
  assign col_sum    = {5'd0, cur.column_accum} * (crp_pkg::COL_ACC_W + 5)'(crp_pkg::RADIX_COL)
                    + (crp_pkg::COL_ACC_W + 5)'(letter_val);
  assign row_sum    = {4'd0, cur.row_accum} * (crp_pkg::ROW_ACC_W + 4)'(crp_pkg::RADIX_ROW)
                    + (crp_pkg::ROW_ACC_W + 4)'(digit_val);

  always_comb begin
    cur_next   = cur;
    phase_next = phase;
    consumed   = 1'b0;
    take_row   = 1'b0;
    if (phase == PHASE_START) begin
      phase_next = PHASE_LETTERS;
      if (s0_char == crp_pkg::CHAR_DOLLAR) begin
        cur_next.col_abs = 1'b1;
        consumed         = 1'b1;
      end
    end
    if (!consumed) begin
      if (phase_next == PHASE_LETTERS) begin
        if (is_letter) begin
          if (col_sum > (crp_pkg::COL_ACC_W + 5)'(crp_pkg::COL_SAT)) begin
            cur_next.column_accum = crp_pkg::COL_SAT;
          end else begin
            cur_next.column_accum = col_sum[crp_pkg::COL_ACC_W-1:0];
          end
          if (cur.letter_count <= crp_pkg::LETTER_CNT_W'(crp_pkg::MAX_LETTERS)) begin
            cur_next.letter_count = cur.letter_count + 1'b1;
          end
        end else if (s0_char == crp_pkg::CHAR_DOLLAR) begin
          cur_next.row_abs = 1'b1;
          phase_next       = PHASE_ROW;
        end else begin
          phase_next = PHASE_ROW;
          take_row   = 1'b1;
        end
      end else begin
        take_row = 1'b1;
      end
    end
    if (take_row) begin
      if (cur.digit_count <= crp_pkg::DIGIT_CNT_W'(crp_pkg::MAX_DIGITS)) begin
        cur_next.digit_count = cur.digit_count + 1'b1;
      end
      if (is_digit) begin
        if (row_sum > (crp_pkg::ROW_ACC_W + 4)'(crp_pkg::ROW_SAT)) begin
          cur_next.row_accum = crp_pkg::ROW_SAT;
        end else begin
          cur_next.row_accum = row_sum[crp_pkg::ROW_ACC_W-1:0];
        end
      end else begin
        cur_next.row_bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s0_valid <= 1'b1;
    end else if (s0_adv) begin
      s0_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s0_char <= char_code;
      s0_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_START;
      cur   <= '0;
    end else if (s0_adv) begin
      if (s0_last) begin
        phase <= PHASE_START;
        cur   <= '0;
      end else begin
        phase <= phase_next;
        cur   <= cur_next;
      end
    end
  end

  `CRP_ASSERT_NEXT(a_clear_after_last, clk, rst, fin_valid,
                   phase == PHASE_START && cur == '0)
  `CRP_ASSERT_SAME(a_start_is_clean, clk, rst, phase == PHASE_START,
                   cur.letter_count == '0 && cur.digit_count == '0 && !cur.col_abs)
  `CRP_ASSERT_SAME(a_column_saturates, clk, rst, 1'b1, cur.column_accum <= crp_pkg::COL_SAT)
  `CRP_ASSERT_NEXT(a_held_char, clk, rst, s0_valid && !s0_adv,
                   s0_valid && $stable(s0_char) && $stable(s0_last))

endmodule

>>> hdl/crp_result.sv
// range checks and result register of the cell reference parser
// depends on crp_pkg and cell_reference_parser_assert.svh
`include "cell_reference_parser_assert.svh"

module crp_result (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fin_valid,
  input  crp_pkg::parse_t           fin,
  input  logic [crp_pkg::ROW_W-1:0] row_limit,
  input  logic [crp_pkg::COL_W-1:0] column_limit,
  output logic                      out_free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [crp_pkg::ROW_W-1:0] row_index,
  output logic [crp_pkg::COL_W-1:0] column_index,
  output logic                      row_absolute,
  output logic                      column_absolute,
  output logic                      ref_valid
);

  logic                            col_ok;
  logic                            row_ok;
  logic                            ok;
  logic [crp_pkg::ROW_ACC_W-1:0]   row_m1;
  logic [crp_pkg::COL_ACC_W-1:0]   col_m1;

  assign out_free = !out_valid || out_ready;

  assign col_ok = (fin.letter_count != '0)
               && (fin.letter_count <= crp_pkg::LETTER_CNT_W'(crp_pkg::MAX_LETTERS))
               && (fin.column_accum != '0)
               && (fin.column_accum <= {1'b0, column_limit});
  assign row_ok = (fin.digit_count != '0)
               && (fin.digit_count <= crp_pkg::DIGIT_CNT_W'(crp_pkg::MAX_DIGITS))
               && !fin.row_bad
               && (fin.row_accum != '0)
               && (fin.row_accum <= {2'b0, row_limit});
  assign ok     = col_ok && row_ok;
  assign row_m1 = fin.row_accum - crp_pkg::ROW_ACC_W'(1);
  assign col_m1 = fin.column_accum - crp_pkg::COL_ACC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fin_valid) begin
      row_index       <= ok ? row_m1[crp_pkg::ROW_W-1:0] : '0;
      column_index    <= ok ? col_m1[crp_pkg::COL_W-1:0] : '0;
      row_absolute    <= ok && fin.row_abs;
      column_absolute <= ok && fin.col_abs;
      ref_valid       <= ok;
    end
  end

  `CRP_ASSERT_NEXT(a_load_shows, clk, rst, fin_valid, out_valid)
  `CRP_ASSERT_SAME(a_invalid_zero, clk, rst, out_valid && !ref_valid,
                   row_index == '0 && column_index == '0 && !row_absolute && !column_absolute)
  `CRP_ASSERT_SAME(a_valid_in_range, clk, rst, out_valid && ref_valid,
                   row_index != '1 && column_index != '1)

endmodule

>>> hdl/cell_reference_parser.sv
// top level of the cell reference parser: one character per cycle
// out_valid rises once the last character has passed the input register
// and the result register; throughput one character a cycle unless stalled
// a held result stalls input only when the next last character arrives
// reset clears the parse state and sets row_limit 32767, column_limit 702
module cell_reference_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [crp_pkg::CHAR_W-1:0]      char_code,
  input  logic                            is_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [crp_pkg::ROW_W-1:0]       row_index,
  output logic [crp_pkg::COL_W-1:0]       column_index,
  output logic                            row_absolute,
  output logic                            column_absolute,
  output logic                            ref_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [crp_pkg::ROW_W-1:0] row_limit;
  logic [crp_pkg::COL_W-1:0] column_limit;
  logic                      out_free;
  logic                      fin_valid;
  crp_pkg::parse_t           fin;

  crp_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row_limit    (row_limit),
    .column_limit (column_limit)
  );

  crp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .is_last   (is_last),
    .out_free  (out_free),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  crp_result u_result (
    .clk             (clk),
    .rst             (rst),
    .fin_valid       (fin_valid),
    .fin             (fin),
    .row_limit       (row_limit),
    .column_limit    (column_limit),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .row_index       (row_index),
    .column_index    (column_index),
    .row_absolute    (row_absolute),
    .column_absolute (column_absolute),
    .ref_valid       (ref_valid)
  );

endmodule
